### hdl/pti_pkg.sv
// ----------------------------------------------------------------------------
// pti_pkg: shared types and constants of the padded trace interpolator
// Holds the sequencer state type and the default sizes of the block.
// ----------------------------------------------------------------------------
package pti_pkg;

    localparam int          MAX_PAD_RUN_DEF = 63;
    localparam int          SAMPLE_BITS_DEF = 16;
    localparam int          NUM_CH          = 4;
    localparam int          CH_W            = 2;
    localparam int          OUT_W           = 16;
    localparam int          SYM_W           = 8;
    localparam logic [7:0]  PAD_SYMBOL_RST  = 8'd42;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_EMIT,
        S_COPY
    } t_state;

endpackage

### hdl/padded_trace_interpolator.sv
// ----------------------------------------------------------------------------
// padded_trace_interpolator: linear gap fill of pad runs in a four-channel trace
// Pads are held and later replaced by interpolated samples through one shared
// restoring divider and a per-result remainder stepper.
// ----------------------------------------------------------------------------
// Usage: one input beat carries an envelope symbol, four channel samples and
// an endpoint flag (valid/ready). Result beats leave through one output
// register (valid/ready). The pad symbol is set through a small write channel
// that is always ready; write it only while the block is idle.
// Steps per input beat, with n held pads:
//   held pad: no result
//   pad before the first sample: one all-zero result
//   sample with no held pads: the copy, unless the beat is an endpoint
//   sample releasing n pads: a pass through the shared divider (one channel
//   at a time, one quotient bit a cycle), then n results at one a cycle
//   while the receiver is ready, then the copy unless the beat is an endpoint.
// The input is ready only when the sequencer is idle. When the receiver
// stalls, the output register holds its beat and the sequencer waits.
// Reset clears the held sample, the pad count, the sticky overflow flag and
// sets the pad symbol to 42.
// ----------------------------------------------------------------------------
module padded_trace_interpolator #(
    parameter int MAX_PAD_RUN = pti_pkg::MAX_PAD_RUN_DEF,
    parameter int SAMPLE_BITS = pti_pkg::SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [pti_pkg::SYM_W-1:0]  i_cfg_data,
    // input beats
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [pti_pkg::SYM_W-1:0]  i_envelope_symbol,
    input  logic [15:0]                i_sample_a,
    input  logic [15:0]                i_sample_c,
    input  logic [15:0]                i_sample_g,
    input  logic [15:0]                i_sample_t,
    input  logic                       i_endpoint_only,
    // result beats
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [pti_pkg::OUT_W-1:0]  o_out_a,
    output logic [pti_pkg::OUT_W-1:0]  o_out_c,
    output logic [pti_pkg::OUT_W-1:0]  o_out_g,
    output logic [pti_pkg::OUT_W-1:0]  o_out_t,
    output logic                       o_last_of_run,
    output logic                       o_run_overflow
);

    localparam int PAD_W = $clog2(MAX_PAD_RUN + 1);
    localparam int D_W   = PAD_W + 1;
    localparam int Q_W   = SAMPLE_BITS + 1;
    localparam int BIT_W = $clog2(SAMPLE_BITS);
    localparam int NCH   = pti_pkg::NUM_CH;
    localparam int OW    = pti_pkg::OUT_W;

    pti_pkg::t_state r_state, n_state;

    logic [pti_pkg::SYM_W-1:0]     r_pad;
    logic [SAMPLE_BITS-1:0]        r_prev  [NCH];
    logic [SAMPLE_BITS-1:0]        r_cur   [NCH];
    logic signed [Q_W-1:0]         r_qd    [NCH];
    logic [PAD_W-1:0]              r_rd    [NCH];
    logic signed [Q_W-1:0]         r_acc_q [NCH];
    logic [PAD_W-1:0]              r_acc_r [NCH];
    logic [PAD_W-1:0]              r_pend;
    logic                          r_seen;
    logic                          r_ovf;
    logic                          r_endp;
    logic                          r_zero;
    logic [pti_pkg::CH_W-1:0]      r_ch;
    logic [BIT_W-1:0]              r_bit;
    logic [PAD_W-1:0]              r_x;
    logic [SAMPLE_BITS-1:0]        r_dq;
    logic [PAD_W-1:0]              r_rem;
    logic                          r_neg;

    logic                          r_out_valid;
    logic [OW-1:0]                 r_out_v [NCH];
    logic                          r_out_last;
    logic                          r_out_ovf;

    logic                          w_in_acc;
    logic                          w_is_pad;
    logic                          w_out_free;
    logic                          w_out_load;
    logic                          w_last;
    logic                          w_bit_last;
    logic                          w_x_last;
    logic [D_W-1:0]                w_div;
    logic [SAMPLE_BITS-1:0]        w_smp  [NCH];
    logic signed [Q_W-1:0]         w_diff;
    logic [D_W-1:0]                w_trial;
    logic                          w_ge;
    logic [PAD_W-1:0]              w_rem_nx;
    logic [SAMPLE_BITS-1:0]        w_quo_nx;
    logic [D_W-1:0]                w_sum_r [NCH];
    logic                          w_carry [NCH];
    logic [PAD_W-1:0]              w_acc_r_nx [NCH];
    logic signed [Q_W-1:0]         w_acc_q_nx [NCH];
    logic signed [Q_W-1:0]         w_interp   [NCH];
    logic [OW-1:0]                 w_val      [NCH];

    assign o_cfg_ready = 1'b1;

    assign w_smp[0] = i_sample_a[SAMPLE_BITS-1:0];
    assign w_smp[1] = i_sample_c[SAMPLE_BITS-1:0];
    assign w_smp[2] = i_sample_g[SAMPLE_BITS-1:0];
    assign w_smp[3] = i_sample_t[SAMPLE_BITS-1:0];

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_is_pad   = (i_envelope_symbol == r_pad);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_bit_last = (r_bit == BIT_W'(SAMPLE_BITS - 1));
    assign w_x_last   = (r_x == r_pend);
    assign w_div      = {1'b0, r_pend} + D_W'(1);

    // shared divider: one quotient bit a cycle on the magnitude of the step
    assign w_diff   = $signed({1'b0, r_cur[r_ch]}) - $signed({1'b0, r_prev[r_ch]});
    assign w_trial  = {r_rem, r_dq[SAMPLE_BITS-1]};
    assign w_ge     = (w_trial >= w_div);
    assign w_rem_nx = w_ge ? PAD_W'(w_trial - w_div) : PAD_W'(w_trial);
    assign w_quo_nx = {r_dq[SAMPLE_BITS-2:0], w_ge};

    // remainder stepper, all channels side by side
    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            w_sum_r[i] = {1'b0, r_acc_r[i]} + {1'b0, r_rd[i]};
            w_carry[i] = (w_sum_r[i] >= w_div);
            w_acc_r_nx[i] = w_carry[i] ? PAD_W'(w_sum_r[i] - w_div) : PAD_W'(w_sum_r[i]);
            w_acc_q_nx[i] = r_acc_q[i] + r_qd[i] + (w_carry[i] ? Q_W'(1) : Q_W'(0));
            w_interp[i]   = $signed({1'b0, r_prev[i]}) + w_acc_q_nx[i];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pti_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (w_is_pad) begin
                        if (!r_seen) n_state = pti_pkg::S_COPY;
                    end else if (r_seen && r_pend != '0) begin
                        n_state = pti_pkg::S_LOAD;
                    end else if (!i_endpoint_only) begin
                        n_state = pti_pkg::S_COPY;
                    end
                end
            end
            pti_pkg::S_LOAD: n_state = pti_pkg::S_DIV;
            pti_pkg::S_DIV: begin
                if (w_bit_last) begin
                    n_state = (r_ch == pti_pkg::CH_W'(NCH - 1)) ? pti_pkg::S_EMIT
                                                                : pti_pkg::S_LOAD;
                end
            end
            pti_pkg::S_EMIT: begin
                if (w_out_free && w_x_last) begin
                    n_state = r_endp ? pti_pkg::S_IDLE : pti_pkg::S_COPY;
                end
            end
            pti_pkg::S_COPY: begin
                if (w_out_free) n_state = pti_pkg::S_IDLE;
            end
            default: n_state = pti_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_out_load = 1'b0;
        w_last     = 1'b0;
        for (int i = 0; i < NCH; i++) begin
            w_val[i] = '0;
        end
        case (r_state)
            pti_pkg::S_IDLE: o_in_ready = 1'b1;
            pti_pkg::S_EMIT: begin
                w_out_load = w_out_free;
                w_last     = w_x_last && r_endp;
                for (int i = 0; i < NCH; i++) begin
                    w_val[i] = OW'(w_interp[i][SAMPLE_BITS-1:0]);
                end
            end
            pti_pkg::S_COPY: begin
                w_out_load = w_out_free;
                w_last     = 1'b1;
                for (int i = 0; i < NCH; i++) begin
                    w_val[i] = r_zero ? '0 : OW'(r_cur[i]);
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pti_pkg::S_IDLE;
            r_pad       <= pti_pkg::PAD_SYMBOL_RST;
            r_pend      <= '0;
            r_seen      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_ch        <= '0;
            r_bit       <= '0;
            r_x         <= '0;
            for (int i = 0; i < NCH; i++) begin
                r_prev[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_pad <= i_cfg_data;

            if (w_out_load)       r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;

            case (r_state)
                pti_pkg::S_IDLE: begin
                    r_ch <= '0;
                    r_x  <= PAD_W'(1);
                    if (w_in_acc) begin
                        r_endp <= i_endpoint_only;
                        r_zero <= w_is_pad;
                        for (int i = 0; i < NCH; i++) begin
                            r_cur[i] <= w_smp[i];
                        end
                        if (w_is_pad) begin
                            if (r_seen) begin
                                if (r_pend == PAD_W'(MAX_PAD_RUN)) r_ovf <= 1'b1;
                                else                               r_pend <= r_pend + PAD_W'(1);
                            end
                        end else if (i_endpoint_only && !(r_seen && r_pend != '0)) begin
                            // trace ends with nothing to release
                            r_pend <= '0;
                            r_seen <= 1'b0;
                            for (int i = 0; i < NCH; i++) begin
                                r_prev[i] <= '0;
                            end
                        end
                    end
                end
                pti_pkg::S_LOAD: begin
                    r_neg <= w_diff[Q_W-1];
                    r_dq  <= w_diff[Q_W-1] ? SAMPLE_BITS'(-w_diff) : SAMPLE_BITS'(w_diff);
                    r_rem <= '0;
                    r_bit <= '0;
                end
                pti_pkg::S_DIV: begin
                    r_dq  <= w_quo_nx;
                    r_rem <= w_rem_nx;
                    r_bit <= r_bit + BIT_W'(1);
                    if (w_bit_last) begin
                        // floor toward minus infinity for a falling step
                        if (r_neg && w_rem_nx != '0) begin
                            r_qd[r_ch] <= -$signed({1'b0, w_quo_nx}) - Q_W'(1);
                            r_rd[r_ch] <= PAD_W'(w_div - {1'b0, w_rem_nx});
                        end else if (r_neg) begin
                            r_qd[r_ch] <= -$signed({1'b0, w_quo_nx});
                            r_rd[r_ch] <= '0;
                        end else begin
                            r_qd[r_ch] <= $signed({1'b0, w_quo_nx});
                            r_rd[r_ch] <= w_rem_nx;
                        end
                        r_acc_q[r_ch] <= '0;
                        r_acc_r[r_ch] <= '0;
                        r_ch <= r_ch + pti_pkg::CH_W'(1);
                    end
                end
                pti_pkg::S_EMIT: begin
                    if (w_out_free) begin
                        for (int i = 0; i < NCH; i++) begin
                            r_acc_q[i] <= w_acc_q_nx[i];
                            r_acc_r[i] <= w_acc_r_nx[i];
                        end
                        r_x <= r_x + PAD_W'(1);
                        if (w_x_last && r_endp) begin
                            r_pend <= '0;
                            r_seen <= 1'b0;
                            for (int i = 0; i < NCH; i++) begin
                                r_prev[i] <= '0;
                            end
                        end
                    end
                end
                pti_pkg::S_COPY: begin
                    if (w_out_free && !r_zero) begin
                        r_pend <= '0;
                        r_seen <= 1'b1;
                        for (int i = 0; i < NCH; i++) begin
                            r_prev[i] <= r_cur[i];
                        end
                    end
                end
                default: begin
                    r_ch <= '0;
                end
            endcase
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            for (int i = 0; i < NCH; i++) begin
                r_out_v[i] <= w_val[i];
            end
            r_out_last <= w_last;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_a        = r_out_v[0];
    assign o_out_c        = r_out_v[1];
    assign o_out_g        = r_out_v[2];
    assign o_out_t        = r_out_v[3];
    assign o_last_of_run  = r_out_last;
    assign o_run_overflow = r_out_ovf;

    // pad count stays within the run limit
    a_pend_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PAD_W'(MAX_PAD_RUN))
        else $error("pad count beyond run limit");

    // no pads are held outside a trace
    a_pend_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> r_pend == '0)
        else $error("pads held before any sample");

    // overflow flag is sticky until reset
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag cleared");

    // channel 0 stepper remainder stays below the divisor while results are released
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pti_pkg::S_EMIT |-> ({1'b0, r_acc_r[0]} < w_div)
                                    && ({1'b0, r_rd[0]} < w_div))
        else $error("interpolation remainder out of range");

endmodule

### sim/padded_trace_interpolator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// padded_trace_interpolator_tb: self-checking bench of the pad gap filler
// Drives envelope/sample beats in bursts, keeps its own copy of the held
// sample, pad count and overflow flag, and compares each result beat with
// the interpolated values it works out, under several pad symbol settings.
// ----------------------------------------------------------------------------
module padded_trace_interpolator_tb;

    localparam int OW          = pti_pkg::OUT_W;
    localparam int SW          = pti_pkg::SYM_W;
    localparam int NCH         = pti_pkg::NUM_CH;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int IDLE_WAIT   = 100;     // longer than one divider pass
    localparam int TAIL_WAIT   = 200;
    localparam logic [OW-1:0] SMP_MASK = OW'((1 << pti_pkg::SAMPLE_BITS_DEF) - 1);

    typedef logic [NCH-1:0][OW-1:0] t_ch_vec;

    typedef struct packed {
        t_ch_vec ch;      // a, c, g, t
        logic    last;
        logic    ovf;
    } t_trace_beat;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [SW-1:0]    i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [SW-1:0]    i_envelope_symbol = '0;
    logic [15:0]      i_sample_a = '0;
    logic [15:0]      i_sample_c = '0;
    logic [15:0]      i_sample_g = '0;
    logic [15:0]      i_sample_t = '0;
    logic             i_endpoint_only = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [OW-1:0]    o_out_a;
    logic [OW-1:0]    o_out_c;
    logic [OW-1:0]    o_out_g;
    logic [OW-1:0]    o_out_t;
    logic             o_last_of_run;
    logic             o_run_overflow;

    padded_trace_interpolator u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_envelope_symbol (i_envelope_symbol),
        .i_sample_a        (i_sample_a),
        .i_sample_c        (i_sample_c),
        .i_sample_g        (i_sample_g),
        .i_sample_t        (i_sample_t),
        .i_endpoint_only   (i_endpoint_only),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_a           (o_out_a),
        .o_out_c           (o_out_c),
        .o_out_g           (o_out_g),
        .o_out_t           (o_out_t),
        .o_last_of_run     (o_last_of_run),
        .o_run_overflow    (o_run_overflow)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mirror of the block state
    logic [SW-1:0]    pad_sym = pti_pkg::PAD_SYMBOL_RST;
    t_ch_vec          held_smp = '0;
    int unsigned      held_pads = 0;
    bit               seen_smp = 1'b0;
    bit               ovf_sticky = 1'b0;

    t_trace_beat trace_beats[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          beats_checked = 0;
    int          cfg_writes = 0;
    int          burst_left = 0;
    int          rx_run = 0;
    int          cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: long ready stretches broken by random stalls
    always @(posedge i_clk) begin
        if (rx_run != 0) begin
            rx_run <= rx_run - 1;
        end else if (i_out_ready) begin
            i_out_ready <= 1'b0;
            rx_run      <= $urandom_range(0, 7);
        end else begin
            i_out_ready <= 1'b1;
            rx_run      <= $urandom_range(0, 40);
        end
    end

    task automatic flag_mismatch(input string what, input logic [15:0] exp_v,
                                 input logic [15:0] got_v);
        $display("tb: mismatch on %s beat %0d: expected %h, got %h",
                 what, beats_checked, exp_v, got_v);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_trace_beat b;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (trace_beats.size() == 0) begin
                flag_mismatch("unexpected", 16'h0, o_out_a);
            end else begin
                b = trace_beats.pop_front();
                if (o_out_a !== b.ch[0]) flag_mismatch("out_a", b.ch[0], o_out_a);
                if (o_out_c !== b.ch[1]) flag_mismatch("out_c", b.ch[1], o_out_c);
                if (o_out_g !== b.ch[2]) flag_mismatch("out_g", b.ch[2], o_out_g);
                if (o_out_t !== b.ch[3]) flag_mismatch("out_t", b.ch[3], o_out_t);
                if (o_last_of_run !== b.last)
                    flag_mismatch("last_of_run", 16'(b.last), 16'(o_last_of_run));
                if (o_run_overflow !== b.ovf)
                    flag_mismatch("run_overflow", 16'(b.ovf), 16'(o_run_overflow));
            end
            beats_checked++;
        end
    end

    task automatic push_beat(input t_ch_vec ch, input bit last);
        t_trace_beat b;
        b.ch   = ch;
        b.last = last;
        b.ovf  = ovf_sticky;
        trace_beats.push_back(b);
    endtask

    // one beat per held pad: prev + floor((next - prev) * x / (n + 1))
    task automatic release_held_pads(input t_ch_vec nxt, input bit ends_here);
        int      n;
        longint  den;
        longint  num;
        longint  q;
        t_ch_vec v;
        n   = held_pads;
        den = n + 1;
        for (int x = 1; x <= n; x++) begin
            for (int j = 0; j < NCH; j++) begin
                num = (longint'(nxt[j]) - longint'(held_smp[j])) * x;
                q   = (num >= 0) ? num / den : -((-num + den - 1) / den);
                v[j] = OW'(longint'(held_smp[j]) + q) & SMP_MASK;
            end
            push_beat(v, ends_here && x == n);
        end
    endtask

    task automatic interpolate_item(input logic [SW-1:0] sym, input t_ch_vec raw,
                                    input bit ep);
        t_ch_vec smp;
        for (int j = 0; j < NCH; j++)
            smp[j] = raw[j] & SMP_MASK;
        if (sym == pad_sym) begin
            if (!seen_smp)
                push_beat('0, 1'b1);
            else if (held_pads < pti_pkg::MAX_PAD_RUN_DEF)
                held_pads++;
            else
                ovf_sticky = 1'b1;
        end else if (ep) begin
            if (seen_smp)
                release_held_pads(smp, 1'b1);
            held_smp  = '0;
            held_pads = 0;
            seen_smp  = 1'b0;
        end else begin
            if (seen_smp)
                release_held_pads(smp, 1'b0);
            push_beat(smp, 1'b1);
            held_smp  = smp;
            held_pads = 0;
            seen_smp  = 1'b1;
        end
    endtask

    // valid stays high across a burst; it drops only for a gap or a pause
    task automatic send_item(input logic [SW-1:0] sym, input t_ch_vec smp,
                             input bit ep);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid        <= 1'b1;
        i_envelope_symbol <= sym;
        i_sample_a        <= smp[0];
        i_sample_c        <= smp[1];
        i_sample_g        <= smp[2];
        i_sample_t        <= smp[3];
        i_endpoint_only   <= ep;
        do @(posedge i_clk); while (!o_in_ready);
        interpolate_item(sym, smp, ep);
        items_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (trace_beats.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_pad_symbol(input logic [SW-1:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pad_sym = val;
        cfg_writes++;
    endtask

    function automatic t_ch_vec rand_samples();
        t_ch_vec v;
        for (int j = 0; j < NCH; j++) begin
            case ($urandom_range(0, 7))
                0: v[j] = 16'h0000;
                1: v[j] = 16'hffff;
                default: v[j] = 16'($urandom);
            endcase
        end
        return v;
    endfunction

    function automatic logic [SW-1:0] other_symbol();
        logic [SW-1:0] s;
        s = SW'($urandom);
        if (s == pad_sym)
            s = s ^ SW'($urandom_range(1, 255));
        return s;
    endfunction

    function automatic int pad_run_len();
        int r;
        r = $urandom_range(0, 15);
        if (r < 6)  return 0;
        if (r < 13) return $urandom_range(1, 4);
        if (r < 15) return $urandom_range(5, 12);
        return $urandom_range(13, 20);
    endfunction

    task automatic send_pads(input int n);
        repeat (n) send_item(pad_sym, rand_samples(), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_before_first_sample();
        send_item(pad_sym, '1, 1'b0);
        send_item(pad_sym, '1, 1'b1);        // pad with endpoint flag is still a pad
        send_item(8'h00, rand_samples(), 1'b1);  // endpoint with no trace open
        send_item(8'h00, '0, 1'b0);
        send_item(pad_sym, '0, 1'b0);
        send_item(8'hff, '1, 1'b1);          // endpoint, one held pad
    endtask

    task automatic test_interpolation();
        send_item(8'h41, '0, 1'b0);
        send_pads(3);
        send_item(8'h43, '1, 1'b0);          // rising run
        send_pads(2);
        send_item(8'h47, '0, 1'b0);          // falling run, negative step
        send_item(8'h54, {16'h8000, 16'h1234, 16'hffff, 16'h0000}, 1'b0);
        send_pads(4);
        send_item(8'h00, {16'h0001, 16'hfffe, 16'h7fff, 16'h8001}, 1'b0);
        send_item(8'hff, rand_samples(), 1'b1);  // endpoint with nothing held
        send_item(8'h80, '1, 1'b0);
        send_item(pad_sym, rand_samples(), 1'b1);
        send_pads(1);
        send_item(8'h7f, '0, 1'b1);          // endpoint closing a trailing run
    endtask

    task automatic test_random_traces(input int budget);
        int start;
        int runlen;
        start = items_sent;
        while (items_sent - start < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item($urandom_range(0, 1) ? pad_sym : SW'($urandom),
                          rand_samples(), 1'($urandom_range(0, 1)));
            end else begin
                if ($urandom_range(0, 3) == 0)
                    send_pads($urandom_range(1, 2));
                repeat ($urandom_range(1, 4)) begin
                    send_pads(pad_run_len());
                    send_item(other_symbol(), rand_samples(), 1'b0);
                end
                if ($urandom_range(0, 3) != 0) begin
                    runlen = pad_run_len();
                    send_pads(runlen);
                    send_item(other_symbol(), rand_samples(), 1'b1);
                end
            end
            if ($urandom_range(0, 11) == 0)
                wait_idle();
        end
    endtask

    // runs past the limit: dropped pads, sticky flag, the longest release
    task automatic test_long_pad_runs();
        send_item(other_symbol(), rand_samples(), 1'b0);
        send_pads(pti_pkg::MAX_PAD_RUN_DEF + 2);
        send_item(other_symbol(), rand_samples(), 1'b0);
        send_item(other_symbol(), rand_samples(), 1'b1);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_before_first_sample();
        test_interpolation();
        write_pad_symbol(8'h00);
        test_random_traces(45);
        write_pad_symbol(8'hff);
        test_random_traces(45);
        write_pad_symbol(SW'($urandom));
        test_long_pad_runs();
        write_pad_symbol(SW'($urandom));
        test_random_traces(40);

        i_in_valid <= 1'b0;
        while (trace_beats.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("tb: sent %0d beats under %0d pad symbol writes, checked %0d results",
                 items_sent, cfg_writes, beats_checked);
        $display("tb: covered leading pads, endpoints, long runs past the pad limit");
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches", mismatches);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
